// ===== rtl/wav_header_checker_unit_macros.svh =====
// assertion macros for the wav header checker
`ifndef WAV_HEADER_CHECKER_UNIT_MACROS_SVH
`define WAV_HEADER_CHECKER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, sampled on clk, off during reset
`define WHC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("whc assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define WHC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("whc assertion failed");

`else

`define WHC_ASSERT_NOW(label, ante, cons)
`define WHC_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== rtl/whc_pkg.sv =====
// types and constants shared by the wav header checker
package whc_pkg;

    localparam logic [31:0] TAG_RIFF      = 32'h52494646;
    localparam logic [31:0] TAG_WAVE      = 32'h57415645;
    localparam logic [31:0] TAG_FMT       = 32'h666d7420;
    localparam logic [31:0] TAG_DATA      = 32'h64617461;
    localparam logic [31:0] FMT_PCM_SIZE  = 32'd16;
    localparam logic [15:0] FMT_PCM       = 16'd1;
    localparam logic [31:0] FIRST_CHUNK   = 32'd36;
    localparam logic [31:0] MIN_FILE      = 32'd44;
    localparam logic [31:0] RIFF_OVERHEAD = 32'd8;
    localparam logic [15:0] BITS_NARROW   = 16'd8;
    localparam logic [15:0] BITS_WIDENED  = 16'd16;

    // header byte indexes at which a full word has been assembled
    localparam logic [5:0] IDX_RIFF_TAG  = 6'd3;
    localparam logic [5:0] IDX_RIFF_SIZE = 6'd7;
    localparam logic [5:0] IDX_WAVE_TAG  = 6'd11;
    localparam logic [5:0] IDX_FMT_TAG   = 6'd15;
    localparam logic [5:0] IDX_FMT_SIZE  = 6'd19;
    localparam logic [5:0] IDX_FMT_CHAN  = 6'd23;
    localparam logic [5:0] IDX_FMT_RATE  = 6'd27;
    localparam logic [5:0] IDX_FMT_BITS  = 6'd35;

    // check flag bits
    localparam int FLG_RIFF   = 0;
    localparam int FLG_WAVE   = 1;
    localparam int FLG_FMT    = 2;
    localparam int FLG_SIZE16 = 3;
    localparam int FLG_PCM    = 4;
    localparam int FLG_W      = 5;

    localparam logic [2:0] ERR_OK      = 3'd0;
    localparam logic [2:0] ERR_SHORT   = 3'd1;
    localparam logic [2:0] ERR_RIFF    = 3'd2;
    localparam logic [2:0] ERR_SIZE    = 3'd3;
    localparam logic [2:0] ERR_WAVE    = 3'd4;
    localparam logic [2:0] ERR_FMT     = 3'd5;
    localparam logic [2:0] ERR_NOT_PCM = 3'd6;
    localparam logic [2:0] ERR_NO_DATA = 3'd7;

    // result word, first field in the highest bits
    typedef struct packed {
        logic [3:0]  pad;
        logic [31:0] data_size;
        logic [31:0] audio_start;
        logic [15:0] play_bits;
        logic [31:0] play_rate;
        logic [15:0] bits_per_sample;
        logic [31:0] sample_rate;
        logic [15:0] channels;
        logic [2:0]  error_code;
        logic        header_ok;
    } result_t;

endpackage

// ===== rtl/wav_header_checker_unit.sv =====
// wav header checker: byte stream in, one header verdict per file out
//
// s_* carries the file one byte per word, s_tlast set on the final byte.
// m_* carries one result word per file, raised after the final byte.
// A byte is captured in the input register and examined from there; the result
// word of a file is registered when its last byte is examined.
// One byte is accepted every cycle outside stalls; every step is a compare,
// a byte shift and a 33-bit add between the input register and the state
// registers. The result register decouples the two sides: bytes keep flowing
// while a result waits, and only the next file's last byte stalls until
// m_tready frees the result register.
// Reset clears all parse state (chunk walk restarts at offset 36) and
// drops both valid flags; after each last byte the parse state returns to
// the same values, ready for the next file.
// The byte counter saturates at 2^32-1; bytes beyond that are not examined.
`include "wav_header_checker_unit_macros.svh"

module wav_header_checker_unit
    import whc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // data_byte
    input  logic         s_tlast,   // last_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [183:0] m_tdata    // header_ok, error_code, channels, sample_rate,
                                    // bits_per_sample, play_rate, play_bits,
                                    // audio_start, data_size, zero pad
);

    logic        in_vld_reg;
    logic [7:0]  in_data_reg;
    logic        in_last_reg;
    logic        proc_fire;

    logic [31:0] pos_reg, pos_next;
    logic [31:0] word_reg, word_next;
    logic [31:0] riff_size_reg, riff_size_next;
    logic [15:0] chan_reg, chan_next;
    logic [15:0] bits_reg, bits_next;
    logic [31:0] rate_reg, rate_next;
    logic [32:0] ncp_reg, ncp_next;
    logic [31:0] tag_reg, tag_next;
    logic        found_reg, found_next;
    logic [31:0] found_off_reg, found_off_next;
    logic [31:0] found_size_reg, found_size_next;
    logic [FLG_W-1:0] flags_reg, flags_next;

    logic [31:0] word_in;
    logic [31:0] word_swap;
    logic [33:0] idx_ext;
    logic [33:0] ncp_ext;
    logic [2:0]  code;
    result_t     res_next;
    result_t     res_reg;
    logic        m_valid_reg;

    // a non-last byte never writes the result register, so it never waits
    assign proc_fire = in_vld_reg && (!in_last_reg || !m_valid_reg || m_tready);
    assign s_tready  = !in_vld_reg || proc_fire;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_data_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    always_comb
    begin
        word_in   = {word_reg[23:0], in_data_reg};
        word_swap = {word_in[7:0], word_in[15:8], word_in[23:16], word_in[31:24]};
        idx_ext   = {2'b00, pos_reg};
        ncp_ext   = {1'b0, ncp_reg};

        pos_next        = pos_reg;
        word_next       = word_reg;
        riff_size_next  = riff_size_reg;
        chan_next       = chan_reg;
        bits_next       = bits_reg;
        rate_next       = rate_reg;
        ncp_next        = ncp_reg;
        tag_next        = tag_reg;
        found_next      = found_reg;
        found_off_next  = found_off_reg;
        found_size_next = found_size_reg;
        flags_next      = flags_reg;

        if (!(&pos_reg))
        begin
            word_next = word_in;
            pos_next  = pos_reg + 32'd1;
            if (pos_reg < FIRST_CHUNK)
            begin
                unique case (pos_reg[5:0])
                    IDX_RIFF_TAG:
                    begin
                        if (word_in == TAG_RIFF)
                            flags_next[FLG_RIFF] = 1'b1;
                    end
                    IDX_RIFF_SIZE: riff_size_next = word_swap;
                    IDX_WAVE_TAG:
                    begin
                        if (word_in == TAG_WAVE)
                            flags_next[FLG_WAVE] = 1'b1;
                    end
                    IDX_FMT_TAG:
                    begin
                        if (word_in == TAG_FMT)
                            flags_next[FLG_FMT] = 1'b1;
                    end
                    IDX_FMT_SIZE:
                    begin
                        if (word_swap == FMT_PCM_SIZE)
                            flags_next[FLG_SIZE16] = 1'b1;
                    end
                    IDX_FMT_CHAN:
                    begin
                        if (word_swap[15:0] == FMT_PCM)
                            flags_next[FLG_PCM] = 1'b1;
                        chan_next = word_swap[31:16];
                    end
                    IDX_FMT_RATE: rate_next = word_swap;
                    IDX_FMT_BITS: bits_next = word_swap[31:16];
                    default:
                    begin
                    end
                endcase
            end
            else if (!found_reg)
            begin
                // subchunk header: tag word, then little-endian size word
                if (idx_ext == ncp_ext + 34'd3)
                begin
                    tag_next = word_in;
                end
                else if (idx_ext == ncp_ext + 34'd7)
                begin
                    if (tag_reg == TAG_DATA)
                    begin
                        found_next      = 1'b1;
                        found_off_next  = ncp_reg[31:0] + 32'd8;
                        found_size_next = word_swap;
                    end
                    else
                    begin
                        ncp_next = ncp_reg + {1'b0, word_swap} + 33'd8;
                    end
                end
            end
        end

        // verdict in file check order, from the state after this byte
        priority if (pos_next < MIN_FILE)
            code = ERR_SHORT;
        else if (!flags_next[FLG_RIFF])
            code = ERR_RIFF;
        else if (pos_next - RIFF_OVERHEAD != riff_size_next)
            code = ERR_SIZE;
        else if (!flags_next[FLG_WAVE])
            code = ERR_WAVE;
        else if (!flags_next[FLG_FMT])
            code = ERR_FMT;
        else if (!flags_next[FLG_SIZE16] || !flags_next[FLG_PCM])
            code = ERR_NOT_PCM;
        else if (!found_next)
            code = ERR_NO_DATA;
        else
            code = ERR_OK;

        res_next            = '0;
        res_next.error_code = code;
        if (code == ERR_OK)
        begin
            res_next.header_ok       = 1'b1;
            res_next.channels        = chan_next;
            res_next.sample_rate     = rate_next;
            res_next.bits_per_sample = bits_next;
            res_next.play_rate       = (bits_next == BITS_NARROW) ? (rate_next >> 1)
                                                                   : rate_next;
            res_next.play_bits       = (bits_next == BITS_NARROW) ? BITS_WIDENED
                                                                   : bits_next;
            res_next.audio_start     = found_off_next;
            res_next.data_size       = found_size_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            word_reg       <= '0;
            riff_size_reg  <= '0;
            chan_reg       <= '0;
            bits_reg       <= '0;
            rate_reg       <= '0;
            ncp_reg        <= {1'b0, FIRST_CHUNK};
            tag_reg        <= '0;
            found_reg      <= 1'b0;
            found_off_reg  <= '0;
            found_size_reg <= '0;
            flags_reg      <= '0;
        end
        else if (proc_fire)
        begin
            if (in_last_reg)
            begin
                // end of file: back to the start-of-file state
                pos_reg        <= '0;
                word_reg       <= '0;
                riff_size_reg  <= '0;
                chan_reg       <= '0;
                bits_reg       <= '0;
                rate_reg       <= '0;
                ncp_reg        <= {1'b0, FIRST_CHUNK};
                tag_reg        <= '0;
                found_reg      <= 1'b0;
                found_off_reg  <= '0;
                found_size_reg <= '0;
                flags_reg      <= '0;
            end
            else
            begin
                pos_reg        <= pos_next;
                word_reg       <= word_next;
                riff_size_reg  <= riff_size_next;
                chan_reg       <= chan_next;
                bits_reg       <= bits_next;
                rate_reg       <= rate_next;
                ncp_reg        <= ncp_next;
                tag_reg        <= tag_next;
                found_reg      <= found_next;
                found_off_reg  <= found_off_next;
                found_size_reg <= found_size_next;
                flags_reg      <= flags_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (proc_fire && in_last_reg)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc_fire && in_last_reg)
        begin
            res_reg <= res_next;
        end
    end

    `WHC_ASSERT_NEXT(a_state_cleared_after_last, proc_fire && in_last_reg,
        pos_reg == '0 && ncp_reg == {1'b0, FIRST_CHUNK} && !found_reg && flags_reg == '0)
    `WHC_ASSERT_NOW(a_ok_matches_code, m_valid_reg,
        res_reg.header_ok == (res_reg.error_code == ERR_OK))
    `WHC_ASSERT_NOW(a_failed_fields_zero, m_valid_reg && !res_reg.header_ok,
        res_reg.channels == '0 && res_reg.sample_rate == '0 &&
        res_reg.audio_start == '0 && res_reg.data_size == '0)
    `WHC_ASSERT_NEXT(a_counter_saturates, (&pos_reg) && !(proc_fire && in_last_reg),
        &pos_reg)

endmodule

// ===== verif/wav_header_checker_unit_tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the wav header checker: generated wav byte streams, predicted verdicts
module wav_header_checker_unit_tb
    import whc_pkg::*;
();

    localparam int TX_BYTES    = 1850;
    localparam int HOLD_AT     = 20;
    localparam int HOLD_CYCLES = 1500;
    localparam int IDLE_LIMIT  = 8000;
    localparam int DRAIN       = 20;

    typedef struct packed {
        logic [7:0] b;
        logic       last;
    } byte_item_t;

    // shape of one generated file
    typedef struct {
        logic [31:0] riff_tag;
        logic [31:0] wave_tag;
        logic [31:0] fmt_tag;
        logic [31:0] fmt_size;
        logic [15:0] fmt_code;
        logic [15:0] chan;
        logic [15:0] bits;
        logic [31:0] rate;
        int          n_skip;
        logic [31:0] skip_size;
        bit          has_data;
        bit          dup_data;
        int          data_len;
        int          size_delta;
        int          cut_len;
        int          tail_len;
    } wav_knobs_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = 8'h00;
    logic         s_tlast = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [183:0] m_tdata;

    byte_item_t  pending_bytes[$];
    result_t     verdict_q[$];
    logic [7:0]  fbuf[$];

    int mismatches = 0;
    int verdicts_seen = 0;
    int tx_gap = 0;
    int rx_wait = 0;
    bit tx_burst = 1'b0;
    bit rx_burst = 1'b0;
    int idle_cycles = 0;
    result_t got_word;
    result_t want_word;
    byte_item_t next_item;
    wav_knobs_t k;

    // parse state of the predictor
    logic [31:0]      hdr_pos;
    logic [31:0]      shift_word;
    logic [31:0]      riff_len;
    logic [15:0]      fmt_chan;
    logic [15:0]      fmt_bits;
    logic [31:0]      fmt_rate;
    logic [33:0]      next_hdr;
    logic [31:0]      chunk_tag;
    logic             data_seen;
    logic [31:0]      data_off;
    logic [31:0]      data_len;
    logic [FLG_W-1:0] flags;

    wav_header_checker_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic logic [31:0] swap32(input logic [31:0] w);
        return {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

    task automatic clear_parse();
        hdr_pos    = '0;
        shift_word = '0;
        riff_len   = '0;
        fmt_chan   = '0;
        fmt_bits   = '0;
        fmt_rate   = '0;
        next_hdr   = {2'b00, FIRST_CHUNK};
        chunk_tag  = '0;
        data_seen  = 1'b0;
        data_off   = '0;
        data_len   = '0;
        flags      = '0;
    endtask

    // one accepted byte; pushes the expected verdict on the last byte of a file
    task automatic parse_byte(input logic [7:0] b, input logic last);
        logic [31:0] idx;
        logic [31:0] w;
        logic [2:0]  code;
        result_t     r;
        if (hdr_pos != 32'hFFFF_FFFF)
        begin
            idx = hdr_pos;
            shift_word = {shift_word[23:0], b};
            w = shift_word;
            if (idx < FIRST_CHUNK)
            begin
                if (idx == IDX_RIFF_TAG && w == TAG_RIFF)
                    flags[FLG_RIFF] = 1'b1;
                if (idx == IDX_RIFF_SIZE)
                    riff_len = swap32(w);
                if (idx == IDX_WAVE_TAG && w == TAG_WAVE)
                    flags[FLG_WAVE] = 1'b1;
                if (idx == IDX_FMT_TAG && w == TAG_FMT)
                    flags[FLG_FMT] = 1'b1;
                if (idx == IDX_FMT_SIZE && swap32(w) == FMT_PCM_SIZE)
                    flags[FLG_SIZE16] = 1'b1;
                if (idx == IDX_FMT_CHAN)
                begin
                    if ({w[23:16], w[31:24]} == FMT_PCM)
                        flags[FLG_PCM] = 1'b1;
                    fmt_chan = {w[7:0], w[15:8]};
                end
                if (idx == IDX_FMT_RATE)
                    fmt_rate = swap32(w);
                if (idx == IDX_FMT_BITS)
                    fmt_bits = {w[7:0], w[15:8]};
            end
            else if (!data_seen)
            begin
                // chunk walk: tag word, then size word decides the jump
                if ({2'b00, idx} == next_hdr + 34'd3)
                    chunk_tag = w;
                else if ({2'b00, idx} == next_hdr + 34'd7)
                begin
                    if (chunk_tag == TAG_DATA)
                    begin
                        data_seen = 1'b1;
                        data_off  = 32'(next_hdr + 34'd8);
                        data_len  = swap32(w);
                    end
                    else
                        next_hdr = next_hdr + {2'b00, swap32(w)} + 34'd8;
                end
            end
            hdr_pos = hdr_pos + 32'd1;
        end
        if (last)
        begin
            if (hdr_pos < MIN_FILE)
                code = ERR_SHORT;
            else if (!flags[FLG_RIFF])
                code = ERR_RIFF;
            else if (hdr_pos - RIFF_OVERHEAD != riff_len)
                code = ERR_SIZE;
            else if (!flags[FLG_WAVE])
                code = ERR_WAVE;
            else if (!flags[FLG_FMT])
                code = ERR_FMT;
            else if (!flags[FLG_SIZE16] || !flags[FLG_PCM])
                code = ERR_NOT_PCM;
            else if (!data_seen)
                code = ERR_NO_DATA;
            else
                code = ERR_OK;
            r = '0;
            r.error_code = code;
            if (code == ERR_OK)
            begin
                r.header_ok       = 1'b1;
                r.channels        = fmt_chan;
                r.sample_rate     = fmt_rate;
                r.bits_per_sample = fmt_bits;
                r.play_rate       = (fmt_bits == BITS_NARROW) ? (fmt_rate >> 1) : fmt_rate;
                r.play_bits       = (fmt_bits == BITS_NARROW) ? BITS_WIDENED : fmt_bits;
                r.audio_start     = data_off;
                r.data_size       = data_len;
            end
            verdict_q.push_back(r);
            clear_parse();
        end
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on %s: expected %h, got %h", what, want, got);
        end
    endtask

    function automatic void put_be32(input logic [31:0] v);
        fbuf.push_back(v[31:24]);
        fbuf.push_back(v[23:16]);
        fbuf.push_back(v[15:8]);
        fbuf.push_back(v[7:0]);
    endfunction

    function automatic void put_le32(input logic [31:0] v);
        put_be32(swap32(v));
    endfunction

    function automatic void put_le16(input logic [15:0] v);
        fbuf.push_back(v[7:0]);
        fbuf.push_back(v[15:8]);
    endfunction

    function automatic void put_noise(input int n);
        for (int i = 0; i < n; i++)
            fbuf.push_back(8'($urandom));
    endfunction

    function automatic logic [31:0] pick32();
        case ($urandom_range(0, 5))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] pick16();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic wav_knobs_t base_knobs();
        wav_knobs_t n;
        n.riff_tag   = TAG_RIFF;
        n.wave_tag   = TAG_WAVE;
        n.fmt_tag    = TAG_FMT;
        n.fmt_size   = FMT_PCM_SIZE;
        n.fmt_code   = FMT_PCM;
        n.chan       = pick16();
        n.rate       = pick32();
        case ($urandom_range(0, 3))
            0: n.bits = BITS_NARROW;
            1: n.bits = BITS_WIDENED;
            2: n.bits = 16'd24;
            default: n.bits = pick16();
        endcase
        n.n_skip     = $urandom_range(0, 2);
        n.skip_size  = $urandom_range(0, 6);
        n.has_data   = 1'b1;
        n.dup_data   = 1'b0;
        n.data_len   = $urandom_range(0, 8);
        n.size_delta = 0;
        n.cut_len    = 0;
        n.tail_len   = $urandom_range(0, 3);
        return n;
    endfunction

    // lays out a file in fbuf, riff size patched from the final length
    function automatic void build_wav(input wav_knobs_t n);
        logic [31:0] riff;
        int          sz;
        fbuf.delete();
        put_be32(n.riff_tag);
        put_le32(32'h0);
        put_be32(n.wave_tag);
        put_be32(n.fmt_tag);
        put_le32(n.fmt_size);
        put_le16(n.fmt_code);
        put_le16(n.chan);
        put_le32(n.rate);
        put_le32($urandom);
        put_le16(16'($urandom));
        put_le16(n.bits);
        for (int i = 0; i < n.n_skip; i++)
        begin
            put_be32(($urandom == TAG_DATA) ? 32'h4c495354 : $urandom);
            if (i == 0)
            begin
                put_le32(n.skip_size);
                // a huge first chunk has no body: the jump leaves the file
                if (n.skip_size <= 32'd32)
                    put_noise(int'(n.skip_size));
            end
            else
            begin
                sz = $urandom_range(0, 6);
                put_le32(sz);
                put_noise(sz);
            end
        end
        if (n.has_data)
        begin
            put_be32(TAG_DATA);
            put_le32(n.data_len);
            put_noise(n.data_len);
        end
        if (n.dup_data)
        begin
            put_be32(TAG_DATA);
            put_le32($urandom);
            put_noise(2);
        end
        put_noise(n.tail_len);
        while (n.cut_len != 0 && fbuf.size() > n.cut_len)
            void'(fbuf.pop_back());
        riff = 32'(fbuf.size() - 8 + n.size_delta);
        if (fbuf.size() >= 8)
        begin
            fbuf[4] = riff[7:0];
            fbuf[5] = riff[15:8];
            fbuf[6] = riff[23:16];
            fbuf[7] = riff[31:24];
        end
    endfunction

    function automatic void emit_file();
        byte_item_t it;
        for (int i = 0; i < fbuf.size(); i++)
        begin
            it.b    = fbuf[i];
            it.last = (i == fbuf.size() - 1);
            pending_bytes.push_back(it);
        end
    endfunction

    // stimulus: directed files, then random well-formed files with some broken ones
    initial
    begin
        clear_parse();

        // lone byte marked last
        fbuf.delete();
        fbuf.push_back(8'hFF);
        emit_file();

        // one byte short of the minimum
        k = base_knobs();
        k.n_skip = 0; k.data_len = 0; k.tail_len = 0; k.cut_len = 43;
        build_wav(k); emit_file();

        // minimum valid file, channel count and sample rate at their top, 8-bit audio
        k = base_knobs();
        k.n_skip = 0; k.data_len = 0; k.tail_len = 0;
        k.chan = 16'hFFFF; k.rate = 32'hFFFF_FFFF; k.bits = BITS_NARROW;
        build_wav(k); emit_file();

        // format fields at zero
        k = base_knobs();
        k.chan = 16'h0; k.rate = 32'h0; k.bits = 16'h0; k.data_len = 3;
        build_wav(k); emit_file();

        k = base_knobs(); k.riff_tag = 32'h52494647; build_wav(k); emit_file();
        k = base_knobs(); k.size_delta = 1; build_wav(k); emit_file();
        k = base_knobs(); k.size_delta = -1; build_wav(k); emit_file();
        k = base_knobs(); k.wave_tag = 32'hD7415645; build_wav(k); emit_file();
        k = base_knobs(); k.fmt_tag = 32'h666d7421; build_wav(k); emit_file();
        k = base_knobs(); k.fmt_size = 32'd18; build_wav(k); emit_file();
        k = base_knobs(); k.fmt_code = 16'd3; build_wav(k); emit_file();

        // several faults at once: the first in file order wins
        k = base_knobs();
        k.riff_tag = 32'h0; k.size_delta = -3; k.wave_tag = 32'hFFFF_FFFF;
        build_wav(k); emit_file();

        // no data chunk after a skipped chunk
        k = base_knobs(); k.has_data = 1'b0; k.n_skip = 1; k.skip_size = 4; k.tail_len = 0;
        build_wav(k); emit_file();

        // skipped chunk jumps far beyond the end of the file
        k = base_knobs(); k.n_skip = 1; k.skip_size = 32'hFFFF_FFFF;
        build_wav(k); emit_file();

        // trailing chunk header cut off
        k = base_knobs(); k.has_data = 1'b0; k.n_skip = 0; k.tail_len = 5;
        build_wav(k); emit_file();

        // data found behind two skipped chunks
        k = base_knobs(); k.n_skip = 2; build_wav(k); emit_file();

        // second data chunk ignored
        k = base_knobs(); k.dup_data = 1'b1; build_wav(k); emit_file();

        // 8-bit audio with an odd rate rounds down
        k = base_knobs(); k.bits = BITS_NARROW; k.rate = 32'd44101; build_wav(k); emit_file();

        while (pending_bytes.size() < TX_BYTES)
        begin
            k = base_knobs();
            if ($urandom_range(0, 9) >= 6)
            begin
                case ($urandom_range(0, 10))
                    0: k.riff_tag ^= 32'h1 << $urandom_range(0, 31);
                    1: k.wave_tag ^= 32'h1 << $urandom_range(0, 31);
                    2: k.fmt_tag ^= 32'h1 << $urandom_range(0, 31);
                    3: k.fmt_size = pick32();
                    4: k.fmt_code = 16'($urandom);
                    5: k.size_delta = $urandom_range(0, 8) - 4;
                    6:
                    begin
                        k.has_data = 1'b0;
                        k.tail_len = $urandom_range(0, 7);
                    end
                    7: k.cut_len = $urandom_range(1, 60);
                    8:
                    begin
                        k.n_skip = $urandom_range(1, 2);
                        k.skip_size = $urandom | 32'h100;
                    end
                    9: k.dup_data = 1'b1;
                    default: ;
                endcase
                build_wav(k);
                // plain noise in place of a file now and then
                if ($urandom_range(0, 10) == 0)
                begin
                    fbuf.delete();
                    put_noise($urandom_range(1, 64));
                end
            end
            else
                build_wav(k);
            emit_file();
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_bytes.size() != 0 || s_tvalid || verdict_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN) @(posedge clk);

        if (mismatches == 0 && verdict_q.size() == 0)
            $display("** wav_header_checker_unit: PASSED **");
        else
            $display("** wav_header_checker_unit: FAILED **");
        $finish;
    end

    // byte driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'h00;
            s_tlast  <= 1'b0;
            tx_gap = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                parse_byte(s_tdata, s_tlast);
            if (!s_tvalid || s_tready)
            begin
                if (tx_gap > 0)
                begin
                    s_tvalid <= 1'b0;
                    tx_gap--;
                end
                else if (pending_bytes.size() != 0)
                begin
                    next_item = pending_bytes.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_item.b;
                    s_tlast  <= next_item.last;
                    if ($urandom_range(0, 31) == 0)
                        tx_burst = !tx_burst;
                    tx_gap = tx_burst ? 0 : $urandom_range(0, 4);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // result monitor; one long hold-off lets the input back up
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_wait = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got_word = result_t'(m_tdata);
                if (verdict_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result word %h", m_tdata);
                end
                else
                begin
                    want_word = verdict_q.pop_front();
                    check_field("header_ok", 32'(want_word.header_ok),
                                32'(got_word.header_ok));
                    check_field("error_code", 32'(want_word.error_code),
                                32'(got_word.error_code));
                    check_field("channels", 32'(want_word.channels),
                                32'(got_word.channels));
                    check_field("sample_rate", want_word.sample_rate, got_word.sample_rate);
                    check_field("bits_per_sample", 32'(want_word.bits_per_sample),
                                32'(got_word.bits_per_sample));
                    check_field("play_rate", want_word.play_rate, got_word.play_rate);
                    check_field("play_bits", 32'(want_word.play_bits),
                                32'(got_word.play_bits));
                    check_field("audio_start", want_word.audio_start, got_word.audio_start);
                    check_field("data_size", want_word.data_size, got_word.data_size);
                end
                verdicts_seen++;
                if ($urandom_range(0, 31) == 0)
                    rx_burst = !rx_burst;
                rx_wait = rx_burst ? 0 : $urandom_range(0, 4);
                if (verdicts_seen == HOLD_AT)
                    rx_wait = HOLD_CYCLES;
            end
            m_tready <= (rx_wait == 0);
            if (rx_wait > 0)
                rx_wait--;
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("** wav_header_checker_unit: FAILED **");
                $finish;
            end
        end
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/whc_pkg.sv
rtl/wav_header_checker_unit.sv
verif/wav_header_checker_unit_tb.sv
